FILE: src/tld_pkg.sv
package tld_pkg;

  // Port field widths
  localparam int FUNC_W     = 2;
  localparam int DATA_W     = 8;
  localparam int RLEN_W     = 7;
  localparam int KIND_W     = 2;
  localparam int FILL_W     = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Longest read reply
  localparam logic [RLEN_W-1:0] MAX_READ = 7'd64;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_RX = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TX = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_OUT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IFLAGS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFLAGS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LFLAGS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WERASE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KILL   = 3'd5;

  // Register reset values
  localparam logic [2:0]        IFLAGS_RST = 3'd1;
  localparam logic [2:0]        OFLAGS_RST = 3'd1;
  localparam logic [3:0]        LFLAGS_RST = 4'd7;
  localparam logic [DATA_W-1:0] ERASE_RST  = 8'd127;
  localparam logic [DATA_W-1:0] WERASE_RST = 8'd23;
  localparam logic [DATA_W-1:0] KILL_RST   = 8'd21;

  // Characters
  localparam logic [DATA_W-1:0] CH_NL   = 8'd10;
  localparam logic [DATA_W-1:0] CH_CR   = 8'd13;
  localparam logic [DATA_W-1:0] CH_ESC  = 8'd27;
  localparam logic [DATA_W-1:0] CH_LBRK = 8'h5B;
  localparam logic [DATA_W-1:0] CH_D    = 8'h44;
  localparam logic [DATA_W-1:0] CH_K    = 8'h4B;

  // Erase echo: cursor left, clear to end of line
  localparam logic [2:0] ESC_LAST = 3'd5;

  function automatic logic [DATA_W-1:0] esc_seq_byte(input logic [2:0] idx);
    logic [DATA_W-1:0] b;
    unique case (idx)
      3'd0, 3'd3: b = CH_ESC;
      3'd1, 3'd4: b = CH_LBRK;
      3'd2:       b = CH_D;
      3'd5:       b = CH_K;
      default:    b = CH_ESC;
    endcase
    return b;
  endfunction

  function automatic logic is_line_end(input logic [DATA_W-1:0] c);
    return (c == CH_NL) || (c == CH_CR);
  endfunction

  // Controller -> datapath
  typedef struct packed {
    logic load;        // latch the input transaction
    logic store;       // store translated rx byte (if room)
    logic erase;       // drop last stored byte
    logic emit_esc;    // start erase echo sequence
    logic emit_char;   // start translated echo / tx byte
    logic emit_step;   // load next emitted byte into output reg
    logic read_step;   // load next ring byte into output reg
    logic read_empty;  // load the empty read result
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              rx_drop;
    logic              do_erase;
    logic              do_store;
    logic              echo;
    logic [1:0]        char_len;
    logic              emit_last;
    logic              read_none;
    logic              read_last;
    logic              out_free;
  } sts_t;

endpackage

FILE: src/tty_line_discipline.sv
// Terminal line discipline over a BUF_DEPTH-entry byte ring (holds up to BUF_DEPTH-1
// bytes). Each input transaction is one of: a received byte (func 0), which gets
// input translation and then erases the last stored byte, is dropped as
// word-erase or kill, or is stored and echoed; a read request (func 1), which
// returns stored bytes - through the first CR/NL in canonical mode, everything
// otherwise - capped at read_len and at 64; or a transmit byte (func 2), which
// goes out through output translation. func 3 is ignored. Results leave on the
// output channel, zero or more per transaction, kind 0 for terminal output, 1 for
// read data, 2 for a read that found nothing; last marks the final result of an
// input transaction, and fill is the ring occupancy right after that result. One
// item is handled at a time: it is accepted, decoded against the registered ring
// read, and its results are loaded one by one into the output register, each once
// that register is free. This order follows from the single registered read port
// of the ring RAM and the one-deep output register; a new input is taken as soon
// as the last result is loaded, even while it still waits for out_ready. The ring
// needs no clearing after reset. Registers (input_flags, output_flags,
// local_flags, erase_char, word_erase_char, kill_char at indexes 0..5) are
// written through cfg_we/cfg_index/cfg_data and must only change while idle.
module tty_line_discipline #(
  parameter int BUF_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [tld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tld_pkg::CFG_DATA_W-1:0] cfg_data,
  // input transactions
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tld_pkg::FUNC_W-1:0]     func,
  input  logic [tld_pkg::DATA_W-1:0]     data,
  input  logic [tld_pkg::RLEN_W-1:0]     read_len,
  // result transactions
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tld_pkg::KIND_W-1:0]     kind,
  output logic [tld_pkg::DATA_W-1:0]     byte_out,
  output logic                           last,
  output logic [tld_pkg::FILL_W-1:0]     fill
);
  import tld_pkg::*;

  cmd_t cmd;   // sequencer commands
  sts_t sts;   // decode results back to the sequencer

  // Sequencer: idle -> decide -> emit/read loop -> idle
  tld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Ring, pointers, translation and the output register
  tld_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .func      (func),
    .data      (data),
    .read_len  (read_len),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .kind      (kind),
    .byte_out  (byte_out),
    .last      (last),
    .fill      (fill)
  );

endmodule

FILE: src/tld_ram.sv
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/tld_ctrl.sv
module tld_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tld_pkg::sts_t sts,
  output tld_pkg::cmd_t cmd
);
  import tld_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECIDE = 4'b0010,
    ST_EMIT   = 4'b0100,
    ST_READ   = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = ST_IDLE;
        unique case (sts.func)
          FUNC_RX: begin
            if (!sts.rx_drop) begin
              if (sts.do_erase) begin
                cmd.erase    = 1'b1;
                cmd.emit_esc = 1'b1;
                state_next   = ST_EMIT;
              end else begin
                cmd.store = sts.do_store;
                if (sts.echo && (sts.char_len != 2'd0)) begin
                  cmd.emit_char = 1'b1;
                  state_next    = ST_EMIT;
                end
              end
            end
          end
          FUNC_TX: begin
            if (sts.char_len != 2'd0) begin
              cmd.emit_char = 1'b1;
              state_next    = ST_EMIT;
            end
          end
          FUNC_RD: begin
            if (sts.read_none) begin
              // hold here until the output register frees up
              if (sts.out_free) begin
                cmd.read_empty = 1'b1;
              end else begin
                state_next = ST_DECIDE;
              end
            end else begin
              state_next = ST_READ;
            end
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_READ: begin
        if (sts.out_free) begin
          cmd.read_step = 1'b1;
          if (sts.read_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_load_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_step || cmd.read_step || cmd.read_empty) |-> sts.out_free)
    else $error("result loaded while output register busy");
`endif

endmodule

FILE: src/tld_datapath.sv
module tld_datapath #(
  parameter int BUF_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tld_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tld_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [tld_pkg::FUNC_W-1:0]           func,
  input  logic [tld_pkg::DATA_W-1:0]           data,
  input  logic [tld_pkg::RLEN_W-1:0]           read_len,
  input  tld_pkg::cmd_t                        cmd,
  output tld_pkg::sts_t                        sts,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [tld_pkg::KIND_W-1:0]           kind,
  output logic [tld_pkg::DATA_W-1:0]           byte_out,
  output logic                                 last,
  output logic [tld_pkg::FILL_W-1:0]           fill
);
  import tld_pkg::*;

  localparam int               PTR_W    = $clog2(BUF_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUF_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_LAST : p - PTR_W'(1);
  endfunction

  // configuration
  logic [2:0]        iflags;
  logic [2:0]        oflags;
  logic [3:0]        lflags;
  logic [DATA_W-1:0] erase_ch;
  logic [DATA_W-1:0] werase_ch;
  logic [DATA_W-1:0] kill_ch;

  // latched transaction
  logic [FUNC_W-1:0] func_q;
  logic [DATA_W-1:0] data_q;
  logic [RLEN_W-1:0] rlen_q;

  // ring state
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [PTR_W-1:0] cnt;
  logic [PTR_W-1:0] lec;

  // sequencing
  logic              emit_esc;
  logic [2:0]        emit_idx;
  logic [RLEN_W-1:0] nread;

  // ring memory
  logic              wr_en;
  logic [PTR_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;
  logic [FUNC_W-1:0] rd_func;

  // decode
  logic [DATA_W-1:0] rx_char;
  logic [DATA_W-1:0] src_char;
  logic [DATA_W-1:0] char_byte;
  logic [DATA_W-1:0] emit_byte;
  logic [1:0]        char_len;
  logic [RLEN_W-1:0] want;
  logic              canon;
  logic              canon_erase;
  logic              canon_kill;
  logic              rd_le;
  logic              full;
  logic              do_erase;
  logic              do_store;
  logic              echo;
  logic              emit_last;
  logic              read_last;
  logic              read_none;
  logic              out_free;

  tld_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BUF_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wp),
    .wdata (rx_char),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign canon       = lflags[0];
  assign canon_erase = lflags[0] & lflags[2];
  assign canon_kill  = lflags[0] & lflags[3];
  assign full        = (cnt == PTR_LAST);
  assign rd_le       = is_line_end(rdata);
  assign out_free    = !out_valid || out_ready;

  // input translation
  always_comb begin
    rx_char = data_q;
    if ((data_q == CH_CR) && iflags[0]) begin
      rx_char = CH_NL;
    end else if ((data_q == CH_NL) && iflags[1]) begin
      rx_char = CH_CR;
    end
  end

  // rx byte classes; erase looks at the byte before wp (rdata)
  always_comb begin
    do_erase = 1'b0;
    do_store = 1'b0;
    echo     = 1'b0;
    priority if (rx_char == erase_ch) begin
      if (canon_erase) begin
        do_erase = (cnt != '0) && !rd_le;
      end else begin
        do_store = 1'b1;
      end
    end else if (rx_char == werase_ch) begin
      do_store = !canon_erase;
    end else if (rx_char == kill_ch) begin
      do_store = !canon_kill;
    end else begin
      do_store = 1'b1;
      echo     = lflags[1];
    end
  end

  // output translation
  assign src_char = (func_q == FUNC_RX) ? rx_char : data_q;

  always_comb begin
    priority if ((src_char == CH_NL) && oflags[0]) begin
      char_len  = 2'd2;
      char_byte = (emit_idx == 3'd0) ? CH_CR : CH_NL;
    end else if ((src_char == CH_CR) && oflags[1]) begin
      char_len  = 2'd1;
      char_byte = CH_NL;
    end else if ((src_char == CH_CR) && oflags[2]) begin
      char_len  = 2'd0;
      char_byte = src_char;
    end else begin
      char_len  = 2'd1;
      char_byte = src_char;
    end
  end

  assign emit_byte = emit_esc ? esc_seq_byte(emit_idx) : char_byte;
  assign emit_last = emit_esc ? (emit_idx == ESC_LAST)
                              : (emit_idx == (3'(char_len) - 3'd1));

  // read length and stop conditions
  assign want      = (rlen_q > MAX_READ) ? MAX_READ : rlen_q;
  assign read_none = (want == '0) || (canon ? (lec == '0) : (cnt == '0));
  assign read_last = (canon ? rd_le : (cnt == PTR_W'(1))) || ((nread + RLEN_W'(1)) == want);

  // memory read address: read side walks rp, rx side peeks at the last byte
  assign rd_func = cmd.load ? func : func_q;
  assign raddr   = (rd_func == FUNC_RD) ? (cmd.read_step ? ptr_inc(rp) : rp) : ptr_dec(wp);
  assign wr_en   = cmd.store && !full;

  always_comb begin
    sts           = '0;
    sts.func      = func_q;
    sts.rx_drop   = (data_q == CH_CR) && iflags[2];
    sts.do_erase  = do_erase;
    sts.do_store  = do_store;
    sts.echo      = echo;
    sts.char_len  = char_len;
    sts.emit_last = emit_last;
    sts.read_none = read_none;
    sts.read_last = read_last;
    sts.out_free  = out_free;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iflags    <= IFLAGS_RST;
      oflags    <= OFLAGS_RST;
      lflags    <= LFLAGS_RST;
      erase_ch  <= ERASE_RST;
      werase_ch <= WERASE_RST;
      kill_ch   <= KILL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IFLAGS: iflags    <= cfg_data[2:0];
        CFG_OFLAGS: oflags    <= cfg_data[2:0];
        CFG_LFLAGS: lflags    <= cfg_data[3:0];
        CFG_ERASE:  erase_ch  <= cfg_data;
        CFG_WERASE: werase_ch <= cfg_data;
        CFG_KILL:   kill_ch   <= cfg_data;
        default: ;
      endcase
    end
  end

  // transaction payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      data_q <= data;
      rlen_q <= read_len;
    end
  end

  // ring pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
      lec <= '0;
    end else begin
      priority if (wr_en) begin
        wp  <= ptr_inc(wp);
        cnt <= cnt + PTR_W'(1);
        if (is_line_end(rx_char)) begin
          lec <= lec + PTR_W'(1);
        end
      end else if (cmd.erase) begin
        wp  <= ptr_dec(wp);
        cnt <= cnt - PTR_W'(1);
      end else if (cmd.read_step) begin
        rp  <= ptr_inc(rp);
        cnt <= cnt - PTR_W'(1);
        if (rd_le && (lec != '0)) begin
          lec <= lec - PTR_W'(1);
        end
      end
    end
  end

  // emit / read sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_esc <= 1'b0;
      emit_idx <= '0;
      nread    <= '0;
    end else begin
      priority if (cmd.emit_esc) begin
        emit_esc <= 1'b1;
        emit_idx <= '0;
      end else if (cmd.emit_char) begin
        emit_esc <= 1'b0;
        emit_idx <= '0;
      end else if (cmd.emit_step) begin
        emit_idx <= emit_idx + 3'd1;
      end
      if (cmd.load) begin
        nread <= '0;
      end else if (cmd.read_step) begin
        nread <= nread + RLEN_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_step || cmd.read_step || cmd.read_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.emit_step) begin
      kind     <= KIND_OUT;
      byte_out <= emit_byte;
      last     <= emit_last;
      fill     <= FILL_W'(cnt);
    end else if (cmd.read_step) begin
      kind     <= KIND_READ;
      byte_out <= rdata;
      last     <= read_last;
      fill     <= FILL_W'(cnt - PTR_W'(1));
    end else if (cmd.read_empty) begin
      kind     <= KIND_EMPTY;
      byte_out <= '0;
      last     <= 1'b1;
      fill     <= FILL_W'(cnt);
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= PTR_LAST)
    else $error("ring count beyond capacity");

  a_lec_bound: assert property (@(posedge clk) disable iff (rst)
    lec <= cnt)
    else $error("line end count exceeds held bytes");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    cnt == ((wp >= rp) ? (wp - rp) : (PTR_W'(BUF_DEPTH) - rp + wp)))
    else $error("ring count out of step with pointers");
`endif

endmodule
